>>> sv/tisp_pkg.sv
`default_nettype none
package tisp_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ALPHABET = 26;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int SLOT_DEPTH = MAX_NODES * ALPHABET;
  localparam int SLOT_W = $clog2(SLOT_DEPTH);

  localparam int CMD_W = 2;
  localparam int LETTER_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LETTER_W-1:0] letter;
    logic                walk;
    logic                last;
  } op_t;

endpackage
`default_nettype wire

>>> sv/tisp_ram.sv
`default_nettype none
module tisp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/tisp_front.sv
`default_nettype none
module tisp_front (
  input  wire logic [tisp_pkg::CMD_W-1:0]    cmd,
  input  wire logic [tisp_pkg::LETTER_W-1:0] letter,
  input  wire logic                          empty_word,
  input  wire logic                          last,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          clear_busy,
  input  wire logic                          queue_full,
  output logic                               push,
  output tisp_pkg::op_t                      op
);
  import tisp_pkg::*;

  // Command three behaves as a prefix search, so it is folded in here.
  always_comb begin
    unique case (cmd)
      CMD_INSERT: op.cmd = CMD_INSERT;
      CMD_SEARCH: op.cmd = CMD_SEARCH;
      default:    op.cmd = CMD_PREFIX;
    endcase
    op.letter = letter;
    op.walk   = !empty_word && (int'(letter) < ALPHABET);
    op.last   = last;
  end

  assign in_ready = !clear_busy && !queue_full;
  assign push     = in_valid && in_ready;

endmodule
`default_nettype wire

>>> sv/tisp_queue.sv
`default_nettype none
module tisp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tisp_pkg::op_t din,
  output logic               full,
  input  wire logic          pop,
  output tisp_pkg::op_t      dout,
  output logic               valid
);
  import tisp_pkg::*;

  op_t                entry [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign dout  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= din;
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/tisp_back.sv
`default_nettype none
module tisp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tisp_pkg::op_t op,
  input  wire logic          op_valid,
  output logic               op_pop,
  output logic               clear_busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               hit,
  output logic               status
);
  import tisp_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state;
  logic [SLOT_W-1:0] clr_cnt;
  logic [NODE_W-1:0] walk_node;
  logic [CNT_W-1:0]  nodes_used;
  logic              word_failed;
  logic              store_full;
  op_t               cur;
  logic [SLOT_W-1:0] slot;

  logic [SLOT_W-1:0] slot_calc;
  logic              child_re;
  logic              child_we;
  logic [SLOT_W-1:0] child_waddr;
  logic [NODE_W-1:0] child_wdata;
  logic [NODE_W-1:0] child_rdata;
  logic              mark_we;
  logic [NODE_W-1:0] mark_waddr;
  logic              mark_wdata;
  logic              mark_re;
  logic              mark_rdata;
  logic              alloc;
  logic              out_free;
  logic              fin_go;
  logic              fin_hit;

  assign clear_busy = (state == S_CLEAR);
  assign slot_calc  = SLOT_W'(walk_node) * SLOT_W'(ALPHABET) + SLOT_W'(op.letter);
  assign out_free   = !out_valid || out_ready;
  assign op_pop     = (state == S_IDLE) && op_valid;
  assign child_re   = op_pop && op.walk && !word_failed;
  assign alloc      = (state == S_LOOK) && (child_rdata == '0) && (cur.cmd == CMD_INSERT) &&
                      (nodes_used != CNT_W'(MAX_NODES));
  assign fin_go     = (state == S_FIN) && out_free;
  assign mark_re    = (state == S_MARK);

  assign child_we    = clear_busy || alloc;
  assign child_waddr = clear_busy ? clr_cnt : slot;
  assign child_wdata = clear_busy ? '0 : NODE_W'(nodes_used);

  assign mark_we    = (clear_busy && (clr_cnt < SLOT_W'(MAX_NODES))) ||
                      (fin_go && (cur.cmd == CMD_INSERT) && !word_failed);
  assign mark_waddr = clear_busy ? NODE_W'(clr_cnt) : walk_node;
  assign mark_wdata = !clear_busy;

  always_comb begin
    unique case (cur.cmd) inside
      CMD_INSERT, CMD_PREFIX: fin_hit = !word_failed;
      CMD_SEARCH:             fin_hit = !word_failed && mark_rdata;
      default:                fin_hit = !word_failed;
    endcase
  end

  tisp_ram #(
    .WIDTH(NODE_W),
    .DEPTH(SLOT_DEPTH)
  ) u_child_ram (
    .clk  (clk),
    .we   (child_we),
    .waddr(child_waddr),
    .wdata(child_wdata),
    .re   (child_re),
    .raddr(slot_calc),
    .rdata(child_rdata)
  );

  tisp_ram #(
    .WIDTH(1),
    .DEPTH(MAX_NODES)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .re   (mark_re),
    .raddr(walk_node),
    .rdata(mark_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      walk_node   <= '0;
      nodes_used  <= CNT_W'(1);
      word_failed <= 1'b0;
      store_full  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= fin_go || (out_valid && !out_ready);
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == SLOT_W'(SLOT_DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (op_valid) begin
            cur  <= op;
            slot <= slot_calc;
            if (child_re) begin
              state <= S_LOOK;
            end else if (op.last) begin
              state <= S_MARK;
            end
          end
        end
        S_LOOK: begin
          if (child_rdata != '0) begin
            walk_node <= child_rdata;
          end else if (alloc) begin
            walk_node  <= NODE_W'(nodes_used);
            nodes_used <= nodes_used + 1'b1;
          end else if (cur.cmd == CMD_INSERT) begin
            word_failed <= 1'b1;
            store_full  <= 1'b1;
          end else begin
            word_failed <= 1'b1;
          end
          state <= cur.last ? S_MARK : S_IDLE;
        end
        S_MARK: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            hit         <= fin_hit;
            status      <= store_full;
            walk_node   <= '0;
            word_failed <= 1'b0;
            store_full  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/trie_insert_search_prefix_top.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  cmd, letter, empty_word, last
// out      output     out_valid/ out_ready hit, status
//
// For a walking letter, S_IDLE reads its child link and S_LOOK acts on it.
// The last item of a word then goes through S_MARK for the end-mark read and S_FIN for the result.
// After reset a clearing pass over all MAX_NODES * ALPHABET child slots (26624) runs; in_ready is low.
// A two-item queue lets the input side run ahead while the walk or the output stalls.
// The result register frees as soon as out_ready is seen.
`default_nettype none
module trie_insert_search_prefix_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tisp_pkg::CMD_W-1:0]    cmd,
  input  wire logic [tisp_pkg::LETTER_W-1:0] letter,
  input  wire logic                          empty_word,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic                               status
);
  import tisp_pkg::*;

  op_t  push_op;
  op_t  pop_op;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_valid;
  logic clear_busy;

  tisp_front u_front (
    .cmd       (cmd),
    .letter    (letter),
    .empty_word(empty_word),
    .last      (last),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .clear_busy(clear_busy),
    .queue_full(queue_full),
    .push      (push),
    .op        (push_op)
  );

  tisp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_op),
    .full (queue_full),
    .pop  (pop),
    .dout (pop_op),
    .valid(queue_valid)
  );

  tisp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op        (pop_op),
    .op_valid  (queue_valid),
    .op_pop    (pop),
    .clear_busy(clear_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .status    (status)
  );

endmodule
`default_nettype wire

>>> sv/tisp_checker.sv
`default_nettype none
module tisp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [tisp_pkg::CMD_W-1:0]    cmd,
  input wire logic [tisp_pkg::LETTER_W-1:0] letter,
  input wire logic                          empty_word,
  input wire logic                          last,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          hit,
  input wire logic                          status
);

  // A full store always fails the word, so a status flag never comes with a hit.
  a_status_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(status && hit))
    else $error("status set together with hit");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ports not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(status))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(letter) &&
      $stable(empty_word) && $stable(last))
    else $error("stalled input item changed");

endmodule

bind trie_insert_search_prefix_top tisp_checker u_tisp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .letter    (letter),
  .empty_word(empty_word),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .status    (status)
);
`default_nettype wire

>>> tb/tb_trie_insert_search_prefix_top.sv
`timescale 1ns / 1ps
module tb_trie_insert_search_prefix_top;
  import tisp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 3 * SLOT_DEPTH;
  localparam int ITEM_GOAL = 1850;
  localparam int MAX_LEN = 12;

  typedef struct packed {
    logic hit;
    logic status;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    c;
    logic [LETTER_W-1:0] l;
    logic                e;
    logic                lst;
    logic                typed;
    logic                h;
    logic                s;
  } plan_row_t;

  localparam plan_row_t PLAN [24] = '{
    '{CMD_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_PREFIX, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_INSERT, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 5'd25, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_SEARCH, 5'd25, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_PREFIX, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_SEARCH, 5'd1,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_PREFIX, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_PREFIX, 5'd25, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 5'd26, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 5'd2,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_SEARCH, 5'd2,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_SPARE,  5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_SEARCH, 5'd16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 5'd17, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 5'd5,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_SEARCH, 5'd25, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_PREFIX, 5'd16, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd;
  logic [LETTER_W-1:0] letter;
  logic                empty_word;
  logic                last;
  logic                out_valid;
  logic                out_ready;
  logic                hit;
  logic                status;

  bit [NODE_W-1:0] trie_kids [SLOT_DEPTH];
  bit              word_end [MAX_NODES];
  int              node_count = 1;
  int              walk_at = 0;
  bit              walk_dead = 1'b0;
  bit              ran_out = 1'b0;

  result_t         pending_q [$];
  logic [5*MAX_LEN-1:0] word_bank [$];
  int              word_bank_len [$];
  int              items_sent = 0;
  int              in_run = 0;
  int              out_run = 0;
  bit              mismatch = 1'b0;

  trie_insert_search_prefix_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .letter     (letter),
    .empty_word (empty_word),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      run = $urandom_range(8, 40);
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic bit trie_step(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l,
                                   input logic e, input logic lst,
                                   output logic h, output logic s);
    int slot;
    int nxt;
    h = 1'b0;
    s = 1'b0;
    if (!e && !walk_dead && l < ALPHABET) begin
      slot = walk_at * ALPHABET + int'(l);
      nxt = int'(trie_kids[slot]);
      if (nxt != 0) begin
        walk_at = nxt;
      end else if (c == CMD_INSERT) begin
        if (node_count >= MAX_NODES) begin
          walk_dead = 1'b1;
          ran_out = 1'b1;
        end else begin
          trie_kids[slot] = NODE_W'(node_count);
          walk_at = node_count;
          node_count++;
        end
      end else begin
        walk_dead = 1'b1;
      end
    end
    if (!lst) begin
      return 1'b0;
    end
    if (c == CMD_INSERT) begin
      if (!walk_dead) begin
        word_end[walk_at] = 1'b1;
        h = 1'b1;
      end
    end else if (c == CMD_SEARCH) begin
      h = !walk_dead && word_end[walk_at];
    end else begin
      h = !walk_dead;
    end
    s = ran_out;
    walk_at = 0;
    walk_dead = 1'b0;
    ran_out = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l,
                           input logic e, input logic lst,
                           input logic typed, input logic th, input logic ts);
    int wait_n;
    logic h;
    logic s;
    result_t r;
    wait_n = draw_wait(in_run);
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    letter <= l;
    empty_word <= e;
    last <= lst;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    if (trie_step(c, l, e, lst, h, s)) begin
      r.hit = typed ? th : h;
      r.status = typed ? ts : s;
      pending_q = {pending_q, r};
    end
  endtask

  task automatic send_word(input logic [CMD_W-1:0] c, input logic [5*MAX_LEN-1:0] bits,
                           input int len);
    if (len == 0) begin
      send_item(c, LETTER_W'($urandom_range(0, 31)), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    end
    for (int i = 0; i < len; i++) begin
      send_item(c, bits[5*i +: 5], 1'b0, i == len - 1, 1'b0, 1'b0, 1'b0);
    end
  endtask

  initial begin
    int pick;
    int kind;
    int len;
    int keep;
    int k;
    int ins_share;
    logic [5*MAX_LEN-1:0] bits;
    logic [CMD_W-1:0] c;
    logic [LETTER_W-1:0] l;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_INSERT;
    letter <= '0;
    empty_word <= 1'b0;
    last <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      send_item(PLAN[i].c, PLAN[i].l, PLAN[i].e, PLAN[i].lst, PLAN[i].typed, PLAN[i].h,
                PLAN[i].s);
    end

    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      ins_share = (node_count < MAX_NODES) ? 70 : 20;
      kind = $urandom_range(0, 9);
      if (kind <= 5 && word_bank.size() == 0) begin
        kind = 6;
      end
      bits = '0;
      if (pick < ins_share) begin
        len = $urandom_range(1, (node_count < MAX_NODES) ? MAX_LEN : 6);
        keep = 0;
        if (word_bank.size() > 0 && $urandom_range(0, 1) == 1) begin
          k = $urandom_range(0, word_bank.size() - 1);
          bits = word_bank[k];
          keep = $urandom_range(0, word_bank_len[k]);
          len = keep + $urandom_range(0, MAX_LEN - keep);
        end
        for (int i = keep; i < len; i++) begin
          bits[5*i +: 5] = LETTER_W'($urandom_range(0, ALPHABET - 1));
        end
        send_word(CMD_INSERT, bits, len);
        if (word_bank.size() < 400) begin
          word_bank = {word_bank, bits};
          word_bank_len = {word_bank_len, len};
        end
      end else if (kind <= 3) begin
        k = $urandom_range(0, word_bank.size() - 1);
        send_word((kind == 3) ? CMD_INSERT : CMD_SEARCH, word_bank[k], word_bank_len[k]);
      end else if (kind <= 5) begin
        k = $urandom_range(0, word_bank.size() - 1);
        c = CMD_W'($urandom_range(1, 3));
        send_word(c, word_bank[k], $urandom_range(0, word_bank_len[k]));
      end else if (kind == 6) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          bits[5*i +: 5] = LETTER_W'($urandom_range(0, ALPHABET - 1));
        end
        send_word(CMD_W'($urandom_range(1, 3)), bits, len);
      end else if (kind == 7) begin
        if ($urandom_range(0, 1) == 1) begin
          send_item(CMD_W'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)), 1'b1,
                    1'b0, 1'b0, 1'b0, 1'b0);
        end
        send_item(CMD_W'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)), 1'b1, 1'b1,
                  1'b0, 1'b0, 1'b0);
      end else begin
        len = $urandom_range(1, 8);
        k = (word_bank.size() > 0) ? $urandom_range(0, word_bank.size() - 1) : -1;
        for (int i = 0; i < len; i++) begin
          if (k >= 0 && i < word_bank_len[k] && $urandom_range(0, 9) < 7) begin
            l = word_bank[k][5*i +: 5];
          end else begin
            l = LETTER_W'($urandom_range(0, 31));
          end
          send_item(CMD_W'($urandom_range(0, 3)), l, $urandom_range(0, 9) == 0, i == len - 1,
                    1'b0, 1'b0, 1'b0);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!mismatch) begin
      $display("tb_trie_insert_search_prefix_top: PASS");
    end else begin
      $display("tb_trie_insert_search_prefix_top: FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    result_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_wait(out_run);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, hit %0b status %0b", $time, hit, status);
        mismatch = 1'b1;
      end else begin
        want = pending_q.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, hit);
          mismatch = 1'b1;
        end
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0b actual %0b", $time, want.status,
                   status);
          mismatch = 1'b1;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("tb_trie_insert_search_prefix_top: FAIL");
    $finish;
  end

endmodule
